// File: src/mvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_pkg
// Transaction types and command and status codes of the matrix-vector
// transform engine.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_IDENT  = 3'd1;
    localparam logic [2:0] CMD_ADDT   = 3'd2;
    localparam logic [2:0] CMD_AFFINE = 3'd3;
    localparam logic [2:0] CMD_ROT    = 3'd4;
    localparam logic [2:0] CMD_TROT   = 3'd5;
    localparam logic [2:0] CMD_INVR   = 3'd6;
    localparam logic [2:0] CMD_PROJ   = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZDIV = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] entry_value;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
        logic               matrix_is_identity;
    } out_t;

endpackage
`default_nettype wire

// File: src/matrix_vector_transform.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_vector_transform
// Fixed-point 4x4 homogeneous matrix-vector transform engine.
// ----------------------------------------------------------------------------
// The 4x4 matrix lives in a 16-entry RAM with a registered read; per-entry
// valid bits make unwritten entries read as identity, so the block is ready
// right after reset with no clearing pass. One transaction is processed at a
// time. Each product reads its entry from the RAM and then runs through one
// shared sequential multiplier (16 bits per cycle). Projective adds a fourth
// row and up to three divisions on a one-bit-per-cycle divider. A finished
// result waits in the output register.
// ----------------------------------------------------------------------------
module matrix_vector_transform
    import mvt_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int E     = ENTRY_WIDTH;
    localparam int VW    = ((E > 32) ? E : 32) + 1;
    localparam int DEPTH = 16;
    localparam logic signed [63:0] EMAX64 = (64'sd1 <<< (E - 1)) - 64'sd1;
    localparam logic signed [63:0] EMIN64 = -EMAX64 - 64'sd1;
    localparam logic signed [63:0] ONE64  = (FRAC_BITS <= E - 2) ?
                                            (64'sd1 <<< FRAC_BITS) : EMAX64;
    localparam logic signed [E-1:0] ONE   = ONE64[E-1:0];

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_WR   = 10'b0000000010,
        S_TRD  = 10'b0000000100,
        S_TUSE = 10'b0000001000,
        S_RD   = 10'b0000010000,
        S_USE  = 10'b0000100000,
        S_MUL  = 10'b0001000000,
        S_ROW  = 10'b0010000000,
        S_DIV  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    function automatic logic signed [E-1:0] sat_v(input logic signed [63:0] v);
        if (v > EMAX64) begin
            return EMAX64[E-1:0];
        end
        if (v < EMIN64) begin
            return EMIN64[E-1:0];
        end
        return v[E-1:0];
    endfunction

    function automatic logic sat_o(input logic signed [63:0] v);
        return (v > EMAX64) || (v < EMIN64);
    endfunction

    function automatic logic signed [E-1:0] idval(input logic [3:0] a);
        return (a[3:2] == a[1:0]) ? ONE : '0;
    endfunction

    function automatic logic signed [31:0] lo32(input logic signed [E-1:0] r);
        logic signed [63:0] x;
        x = 64'(r);
        return x[31:0];
    endfunction

    state_t             state_reg, state_next;
    in_t                in_reg, in_next;
    logic signed [VW-1:0] t_reg [3];
    logic signed [VW-1:0] t_next [3];
    logic [1:0]         i_reg, i_next;
    logic [1:0]         j_reg, j_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] w_reg, w_next;
    logic signed [E-1:0] res_reg [3];
    logic signed [E-1:0] res_next [3];
    logic               flag_reg, flag_next;
    logic               zdiv_reg, zdiv_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [DEPTH-1:0]   nonid_reg, nonid_next;
    logic               rvalid_reg, rvalid_next;
    logic [3:0]         raddr_reg, raddr_next;
    out_t               out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic               ram_we;
    logic [3:0]         ram_waddr;
    logic signed [E-1:0] ram_wdata;
    logic [3:0]         ram_raddr;
    logic [E-1:0]       ram_rdata;
    logic signed [E-1:0] ent;
    logic signed [63:0] ent64;
    logic signed [63:0] sum;

    logic               mul_start, mul_done, mul_ovf;
    logic signed [E-1:0] mul_a;
    logic signed [VW-1:0] mul_b;
    logic signed [63:0] mul_prod;
    logic               div_start, div_done, div_ovf;
    logic signed [E-1:0] div_q;

    logic               transposed, add_en, last_row;

    mvt_ram #(.WIDTH(E), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mvt_mul #(.AW(E), .BW(VW), .FRAC(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod),
        .ovf     (mul_ovf)
    );

    mvt_div #(.EW(E), .FRAC(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_reg),
        .den     (w_reg),
        .done    (div_done),
        .quot    (div_q),
        .ovf     (div_ovf)
    );

    assign ent        = rvalid_reg ? $signed(ram_rdata) : idval(raddr_reg);
    assign ent64      = 64'(ent);
    assign transposed = (in_reg.cmd == CMD_TROT) || (in_reg.cmd == CMD_INVR);
    assign add_en     = (in_reg.cmd == CMD_AFFINE) || (in_reg.cmd == CMD_PROJ);
    assign last_row   = (i_reg == 2'd2);

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        t_next       = t_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        acc_next     = acc_reg;
        w_next       = w_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        zdiv_next    = zdiv_reg;
        valid_next   = valid_reg;
        nonid_next   = nonid_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_waddr    = {in_reg.row, in_reg.col};
        ram_wdata    = '0;
        ram_raddr    = raddr_reg;
        sum          = ent64 + 64'(t_reg[0]);
        mul_start    = 1'b0;
        mul_a        = ent;
        mul_b        = t_reg[0];
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    t_next[0]   = VW'(s_data.vec_x);
                    t_next[1]   = VW'(s_data.vec_y);
                    t_next[2]   = VW'(s_data.vec_z);
                    i_next      = (s_data.cmd == CMD_PROJ) ? 2'd3 : 2'd0;
                    j_next      = 2'd0;
                    acc_next    = '0;
                    flag_next   = 1'b0;
                    zdiv_next   = 1'b0;
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    unique case (s_data.cmd)
                        CMD_WRITE, CMD_IDENT: state_next = S_WR;
                        CMD_ADDT, CMD_INVR:   state_next = S_TRD;
                        default:              state_next = S_RD;
                    endcase
                end
            end
            S_WR: begin
                if (in_reg.cmd == CMD_IDENT) begin
                    valid_next = '0;
                    nonid_next = '0;
                end else begin
                    ram_we     = 1'b1;
                    ram_wdata  = sat_v(64'(in_reg.entry_value));
                    flag_next  = sat_o(64'(in_reg.entry_value));
                    valid_next[ram_waddr] = 1'b1;
                    nonid_next[ram_waddr] = ram_wdata != idval(ram_waddr);
                end
                state_next = S_FIN;
            end
            S_TRD: begin
                ram_raddr  = {j_reg, 2'd3};
                state_next = S_TUSE;
            end
            S_TUSE: begin
                if (in_reg.cmd == CMD_ADDT) begin
                    sum       = ent64 + 64'(t_reg[j_reg]);
                    ram_we    = 1'b1;
                    ram_waddr = {j_reg, 2'd3};
                    ram_wdata = sat_v(sum);
                    flag_next = flag_reg | sat_o(sum);
                    valid_next[ram_waddr] = 1'b1;
                    nonid_next[ram_waddr] = ram_wdata != idval(ram_waddr);
                end else begin
                    t_next[j_reg] = t_reg[j_reg] - VW'(ent);
                end
                if (j_reg == 2'd2) begin
                    i_next     = 2'd0;
                    j_next     = 2'd0;
                    state_next = (in_reg.cmd == CMD_ADDT) ? S_FIN : S_RD;
                end else begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_TRD;
                end
            end
            S_RD: begin
                if (j_reg == 2'd3) begin
                    ram_raddr = {i_reg, 2'd3};
                end else if (transposed) begin
                    ram_raddr = {j_reg, i_reg};
                end else begin
                    ram_raddr = {i_reg, j_reg};
                end
                state_next = S_USE;
            end
            S_USE: begin
                if (j_reg == 2'd3) begin
                    acc_next   = acc_reg + ent64;
                    state_next = S_ROW;
                end else begin
                    mul_start  = 1'b1;
                    mul_b      = t_reg[j_reg];
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    acc_next  = acc_reg + mul_prod;
                    flag_next = flag_reg | mul_ovf;
                    if (j_reg != 2'd2) begin
                        j_next     = j_reg + 2'd1;
                        state_next = S_RD;
                    end else if (add_en) begin
                        j_next     = 2'd3;
                        state_next = S_RD;
                    end else begin
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW: begin
                if (in_reg.cmd == CMD_PROJ && i_reg == 2'd3) begin
                    w_next     = acc_reg;
                    i_next     = 2'd0;
                    j_next     = 2'd0;
                    acc_next   = '0;
                    state_next = S_RD;
                end else if (in_reg.cmd == CMD_PROJ && w_reg != 64'sd0) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    if (in_reg.cmd == CMD_PROJ) begin
                        zdiv_next = 1'b1;
                        if (acc_reg > 64'sd0) begin
                            res_next[i_reg] = EMAX64[E-1:0];
                        end else if (acc_reg < 64'sd0) begin
                            res_next[i_reg] = EMIN64[E-1:0];
                        end else begin
                            res_next[i_reg] = '0;
                        end
                    end else begin
                        res_next[i_reg] = sat_v(acc_reg);
                        flag_next       = flag_reg | sat_o(acc_reg);
                    end
                    i_next     = i_reg + 2'd1;
                    j_next     = 2'd0;
                    acc_next   = '0;
                    state_next = last_row ? S_FIN : S_RD;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_next[i_reg] = div_q;
                    flag_next       = flag_reg | div_ovf;
                    i_next          = i_reg + 2'd1;
                    j_next          = 2'd0;
                    acc_next        = '0;
                    state_next      = last_row ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.out_x  = lo32(res_reg[0]);
                    out_next.out_y  = lo32(res_reg[1]);
                    out_next.out_z  = lo32(res_reg[2]);
                    out_next.status = zdiv_reg ? ST_ZDIV : (flag_reg ? ST_SAT : ST_OK);
                    out_next.matrix_is_identity = ~|nonid_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        rvalid_next = valid_reg[ram_raddr];
        raddr_next  = ram_raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            nonid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            nonid_reg   <= nonid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        t_reg      <= t_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        w_reg      <= w_next;
        res_reg    <= res_next;
        flag_reg   <= flag_next;
        zdiv_reg   <= zdiv_next;
        rvalid_reg <= rvalid_next;
        raddr_reg  <= raddr_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// File: src/mvt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: src/mvt_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_mul
// Sequential fixed-point multiplier: 16 bits of the second operand per cycle,
// then round to nearest (ties away from zero) and cap the magnitude at 2^60.
// ----------------------------------------------------------------------------
module mvt_mul #(
    parameter int AW   = 32,
    parameter int BW   = 33,
    parameter int FRAC = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic                      done,
    output logic signed [63:0]        prod,
    output logic                      ovf
);

    localparam int CW   = 16;
    localparam int NCH  = (BW + CW - 1) / CW;
    localparam int BPW  = NCH * CW;
    localparam int PW   = AW + BPW;
    localparam int CNTW = $clog2(NCH + 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);
    localparam logic [PW-1:0] PCAP = PW'(1) << 60;

    logic [AW-1:0]      ua_reg, ua_next;
    logic [BPW-1:0]     ub_reg, ub_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               ovf_reg, ovf_next;
    logic [AW+CW-1:0]   pp;
    logic [PW-1:0]      rnd;
    logic [60:0]        capm;
    logic [BW-1:0]      ub_mag;

    always_comb begin
        pp        = (AW+CW)'(ua_reg) * (AW+CW)'(ub_reg[BPW-1 -: CW]);
        rnd       = (p_reg + HALF) >> FRAC;
        capm      = (rnd > PCAP) ? 61'(PCAP) : rnd[60:0];
        ub_mag    = b[BW-1] ? BW'(-b) : BW'(b);
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            ua_next  = a[AW-1] ? AW'(-a) : AW'(a);
            ub_next  = BPW'(ub_mag);
            p_next   = '0;
            cnt_next = CNTW'(NCH);
            run_next = 1'b1;
            neg_next = a[AW-1] ^ b[BW-1];
        end else if (run_reg) begin
            p_next   = (p_reg << CW) + PW'(pp);
            ub_next  = ub_reg << CW;
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        if (fin_reg) begin
            ovf_next  = rnd > PCAP;
            prod_next = neg_reg ? -64'(capm) : 64'(capm);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        p_reg    <= p_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

// File: src/mvt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_div
// Restoring divider, one quotient bit per cycle: num * 2^FRAC / den truncated
// toward zero, saturated to an EW-bit signed entry.
// ----------------------------------------------------------------------------
module mvt_div #(
    parameter int EW   = 32,
    parameter int FRAC = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [63:0] den,
    output logic                    done,
    output logic signed [EW-1:0]    quot,
    output logic                    ovf
);

    localparam int NB   = 64 + FRAC;
    localparam int CNTW = $clog2(NB + 1);
    localparam logic [NB-1:0] QMAX = (NB'(1) << (EW - 1)) - NB'(1);

    logic [NB-1:0]      n_reg, n_next;
    logic [NB-1:0]      q_reg, q_next;
    logic [63:0]        d_reg, d_next;
    logic [63:0]        rem_reg, rem_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic signed [EW-1:0] quot_reg, quot_next;
    logic               ovf_reg, ovf_next;
    logic [64:0]        trial;
    logic [64:0]        diff;
    logic [63:0]        n_mag;

    always_comb begin
        trial     = {rem_reg, n_reg[NB-1]};
        diff      = trial - {1'b0, d_reg};
        n_mag     = num[63] ? 64'(-num) : 64'(num);
        n_next    = n_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            n_next   = NB'(n_mag) << FRAC;
            d_next   = den[63] ? 64'(-den) : 64'(den);
            rem_next = '0;
            q_next   = '0;
            cnt_next = CNTW'(NB);
            run_next = 1'b1;
            neg_next = num[63] ^ den[63];
        end else if (run_reg) begin
            n_next = n_reg << 1;
            if (trial >= {1'b0, d_reg}) begin
                rem_next = diff[63:0];
                q_next   = {q_reg[NB-2:0], 1'b1};
            end else begin
                rem_next = trial[63:0];
                q_next   = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        if (fin_reg) begin
            done_next = 1'b1;
            if (neg_reg) begin
                ovf_next  = q_reg > QMAX + NB'(1);
                quot_next = ovf_next ? EW'(QMAX + NB'(1)) : EW'(-q_reg);
            end else begin
                ovf_next  = q_reg > QMAX;
                quot_next = ovf_next ? EW'(QMAX) : EW'(q_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

// File: tb/matrix_vector_transform_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_test
// Self-checking bench for the fixed-point 4x4 transform engine: a table of
// directed transactions, then random command streams, each result compared
// field by field against a bit-accurate software predictor of the matrix.
// ----------------------------------------------------------------------------
module matrix_vector_transform_test;
    import mvt_pkg::*;

    localparam longint EMAX = 64'sd2147483647;
    localparam longint EMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;
    localparam longint PCAP = 64'sd1 << 60;
    localparam logic [127:0] QCAP = 128'd1 << 62;
    localparam int LIMIT = 2000000;

    typedef struct {
        in_t  stim;
        bit   fixed;
        out_t want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    longint mat [4][4];
    out_t   pending_results [$];
    dir_row_t dir_rows [$];
    int  fails = 0;
    int  cycles = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    int  hold_off = 0;

    always #10 aclk = ~aclk;

    matrix_vector_transform DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic longint clamp_entry(longint v, inout bit sat);
        if (v > EMAX) begin
            sat = 1;
            return EMAX;
        end
        if (v < EMIN) begin
            sat = 1;
            return EMIN;
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b, inout bit sat);
        logic [127:0] ua, ub, p;
        logic [127:0] r;
        bit neg;
        ua = a < 0 ? 128'(-a) : 128'(a);
        ub = b < 0 ? 128'(-b) : 128'(b);
        neg = (a < 0) != (b < 0);
        p = ua * ub + (128'd1 << 15);
        r = p >> 16;
        if (r > 128'(PCAP)) begin
            sat = 1;
            r = 128'(PCAP);
        end
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint qdiv(longint num, longint w, inout bit sat);
        logic [127:0] n, d, q, r;
        bit neg;
        n = num < 0 ? 128'(-num) : 128'(num);
        d = w < 0 ? 128'(-w) : 128'(w);
        neg = (num < 0) != (w < 0);
        q = n / d;
        r = n % d;
        if (q > QCAP) q = QCAP;
        for (int i = 0; i < 16; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
            if (q > QCAP) q = QCAP;
        end
        return clamp_entry(neg ? -longint'(q[63:0]) : longint'(q[63:0]), sat);
    endfunction

    function automatic bit mat_is_identity();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (mat[r][c] != ((r == c) ? ONE : 0)) return 0;
        return 1;
    endfunction

    function automatic void load_identity();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                mat[r][c] = (r == c) ? ONE : 0;
    endfunction

    function automatic out_t transform_item(in_t t);
        longint v [3];
        longint tv [3];
        longint res [3];
        longint w, num;
        bit sat;
        bit zdiv;
        out_t o;
        sat = 0;
        zdiv = 0;
        v[0] = t.vec_x;
        v[1] = t.vec_y;
        v[2] = t.vec_z;
        res = '{0, 0, 0};
        case (t.cmd)
            CMD_WRITE: mat[t.row][t.col] = clamp_entry(longint'(t.entry_value), sat);
            CMD_IDENT: load_identity();
            CMD_ADDT: begin
                for (int i = 0; i < 3; i++)
                    mat[i][3] = clamp_entry(mat[i][3] + v[i], sat);
            end
            CMD_AFFINE, CMD_ROT: begin
                for (int i = 0; i < 3; i++)
                    res[i] = clamp_entry(qmul(mat[i][0], v[0], sat)
                        + qmul(mat[i][1], v[1], sat) + qmul(mat[i][2], v[2], sat)
                        + (t.cmd == CMD_AFFINE ? mat[i][3] : 0), sat);
            end
            CMD_TROT, CMD_INVR: begin
                for (int i = 0; i < 3; i++)
                    tv[i] = (t.cmd == CMD_INVR) ? v[i] - mat[i][3] : v[i];
                for (int i = 0; i < 3; i++)
                    res[i] = clamp_entry(qmul(mat[0][i], tv[0], sat)
                        + qmul(mat[1][i], tv[1], sat) + qmul(mat[2][i], tv[2], sat), sat);
            end
            default: begin
                w = qmul(mat[3][0], v[0], sat) + qmul(mat[3][1], v[1], sat)
                    + qmul(mat[3][2], v[2], sat) + mat[3][3];
                for (int i = 0; i < 3; i++) begin
                    num = qmul(mat[i][0], v[0], sat) + qmul(mat[i][1], v[1], sat)
                        + qmul(mat[i][2], v[2], sat) + mat[i][3];
                    if (w == 0)
                        res[i] = num > 0 ? EMAX : (num < 0 ? EMIN : 0);
                    else
                        res[i] = qdiv(num, w, sat);
                end
                zdiv = (w == 0);
            end
        endcase
        o.out_x = res[0][31:0];
        o.out_y = res[1][31:0];
        o.out_z = res[2][31:0];
        o.status = zdiv ? ST_ZDIV : (sat ? ST_SAT : ST_OK);
        o.matrix_is_identity = mat_is_identity();
        return o;
    endfunction

    function automatic in_t make_item(logic [2:0] cmd, logic [1:0] row, logic [1:0] col,
                                      logic [31:0] ev, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
        in_t t;
        t.cmd = cmd;
        t.row = row;
        t.col = col;
        t.entry_value = ev;
        t.vec_x = x;
        t.vec_y = y;
        t.vec_z = z;
        return t;
    endfunction

    function automatic out_t make_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [1:0] st, logic id);
        out_t o;
        o.out_x = x;
        o.out_y = y;
        o.out_z = z;
        o.status = st;
        o.matrix_is_identity = id;
        return o;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic in_t rand_item();
        in_t t;
        t = make_item(3'($urandom_range(0, 7)), 2'($urandom()), 2'($urandom()),
                      rand_value(), rand_value(), rand_value(), rand_value());
        if ($urandom_range(0, 3) != 0) begin
            t.vec_x = 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
            t.vec_y = 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
            t.vec_z = 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
            if (t.cmd == CMD_WRITE && $urandom_range(0, 1))
                t.entry_value = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        end
        return t;
    endfunction

    task automatic send_item(in_t t, bit fixed, out_t want);
        out_t pred;
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle) @(posedge aclk);
        end
        pred = transform_item(t);
        if (fixed && pred !== want) begin
            $display("%0t table row mismatch: expected %h actual %h", $realtime, want, pred);
            fails++;
        end
        pending_results.push_back(pred);
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $realtime, m_data);
                fails++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.out_x !== exp_r.out_x || m_data.out_y !== exp_r.out_y
                    || m_data.out_z !== exp_r.out_z || m_data.status !== exp_r.status
                    || m_data.matrix_is_identity !== exp_r.matrix_is_identity) begin
                    $display("%0t mismatch: expected %h actual %h", $realtime, exp_r, m_data);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("matrix_vector_transform regression: fail");
            $finish;
        end
    end

    initial begin
        load_identity();
        dir_rows.push_back('{make_item(CMD_AFFINE, 0, 0, 0, 32'h0001_0000, 32'h0002_0000,
            32'hfffd_0000), 1, make_result(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
            ST_OK, 1)});
        dir_rows.push_back('{make_item(CMD_PROJ, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0),
            0, '0});
        dir_rows.push_back('{make_item(CMD_WRITE, 3, 3, 0, 0, 0, 0), 1,
            make_result(0, 0, 0, ST_OK, 0)});
        dir_rows.push_back('{make_item(CMD_PROJ, 0, 0, 0, 32'h0001_0000, 32'hffff_0000, 0),
            1, make_result(32'h7fff_ffff, 32'h8000_0000, 0, ST_ZDIV, 0)});
        dir_rows.push_back('{make_item(CMD_IDENT, 0, 0, 0, 0, 0, 0), 1,
            make_result(0, 0, 0, ST_OK, 1)});
        dir_rows.push_back('{make_item(CMD_ADDT, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 5),
            1, make_result(0, 0, 0, ST_OK, 0)});
        dir_rows.push_back('{make_item(CMD_ADDT, 0, 0, 0, 1, 32'hffff_ffff, 0), 1,
            make_result(0, 0, 0, ST_SAT, 0)});
        dir_rows.push_back('{make_item(CMD_AFFINE, 0, 0, 0, 32'h7fff_ffff, 0, 1), 0, '0});
        dir_rows.push_back('{make_item(CMD_INVR, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 9),
            0, '0});
        dir_rows.push_back('{make_item(CMD_WRITE, 0, 1, 32'h8000_0000, 0, 0, 0), 1,
            make_result(0, 0, 0, ST_OK, 0)});
        dir_rows.push_back('{make_item(CMD_WRITE, 1, 0, 32'h7fff_ffff, 0, 0, 0), 1,
            make_result(0, 0, 0, ST_OK, 0)});
        dir_rows.push_back('{make_item(CMD_ROT, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff), 0, '0});
        dir_rows.push_back('{make_item(CMD_TROT, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
            32'h0000_8000), 0, '0});
        dir_rows.push_back('{make_item(CMD_WRITE, 3, 0, 32'h0000_8000, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_item(CMD_PROJ, 0, 0, 0, 32'h0003_0000, 32'hfffe_8000,
            32'h0000_0001), 0, '0});
        dir_rows.push_back('{make_item(CMD_PROJ, 0, 0, 0, 32'hfffe_0000, 0, 32'h7fff_ffff),
            0, '0});
        dir_rows.push_back('{make_item(CMD_IDENT, 0, 0, 0, 0, 0, 0), 1,
            make_result(0, 0, 0, ST_OK, 1)});
        dir_rows.push_back('{make_item(CMD_WRITE, 2, 2, 32'h0001_0000, 0, 0, 0), 1,
            make_result(0, 0, 0, ST_OK, 1)});
        dir_rows.push_back('{make_item(CMD_ROT, 0, 0, 0, 32'h0000_0001, 32'hffff_ffff,
            32'h0000_8000), 1, make_result(1, 32'hffff_ffff, 32'h0000_8000, ST_OK, 1)});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 0;
        recv_idle = 0;
        foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 28 : (phase == 1) ? 87 : 0;
            recv_idle = (phase == 0) ? 87 : (phase == 1) ? 28 : 0;
            for (int n = 0; n < 330; n++) begin
                if (phase == 2 && n == 50) hold_off = 3000;
                if ($urandom_range(0, 19) == 0)
                    send_item(make_item(CMD_IDENT, 0, 0, 0, 0, 0, 0), 0, '0);
                else
                    send_item(rand_item(), 0, '0);
            end
        end
        s_valid <= 1'b0;
        drain();
        if (fails == 0)
            $display("matrix_vector_transform regression: pass");
        else
            $display("matrix_vector_transform regression: fail");
        $finish;
    end
endmodule

// File: sim.f
src/mvt_pkg.sv
src/mvt_ram.sv
src/mvt_mul.sv
src/mvt_div.sv
src/matrix_vector_transform.sv
tb/matrix_vector_transform_test.sv
